>>> src/arsp_pkg.sv
// Package for the average-rate send pacer: field widths, codes, pipeline types.
// Used by arsp_ledger and average_rate_send_pacer_core; no dependencies.
`timescale 1ns / 1ps

package arsp_pkg;

	localparam int unsigned RATE_W    = 20;
	localparam int unsigned NOW_W     = 32;
	localparam int unsigned BYTES_W   = 24;
	localparam int unsigned TOTAL_W   = 48;
	localparam int unsigned PROD_W    = NOW_W + RATE_W;
	// floor(e*r*128/1000) > b  <=>  e*r*16 >= (b+1)*125
	localparam int unsigned CMP_SHIFT = 4;
	localparam int unsigned MS_SCALE  = 125;
	localparam int unsigned CMP_W     = 57;
	localparam int unsigned ADDX_W    = 31;

	localparam int unsigned APB_DW    = 32;
	localparam int unsigned APB_AW    = 3;

	localparam logic [APB_AW-3:0] REG_TARGET_RATE = '0;

	localparam logic MODE_PROBE   = 1'b0;
	localparam logic MODE_HUNGRY  = 1'b1;
	localparam logic STATUS_SENT  = 1'b0;
	localparam logic STATUS_BLOCK = 1'b1;

	typedef enum logic [1:0] {
		KIND_PROBE,
		KIND_RESTART,
		KIND_HUNGRY
	} item_kind_t;

	typedef struct packed {
		item_kind_t              kind;
		logic [PROD_W-1:0]       prod;
		logic [ADDX_W-1:0]       add_x125;
		logic [BYTES_W-1:0]      add;
	} ledger_req_t;

endpackage

>>> src/arsp_ledger.sv
// Byte ledger of the pacer window: allowance compare, saturating charge, result register.
// Depends on arsp_pkg.
`timescale 1ns / 1ps

module arsp_ledger (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  arsp_pkg::ledger_req_t req,
	output logic                status_q
);
	import arsp_pkg::*;

	logic [TOTAL_W-1:0] sent_q;
	// Threshold (sent + 1) * 125, kept alongside the byte count.
	logic [CMP_W-1:0]   thresh_q;
	// Set once the byte count reaches its ceiling: every probe is blocked from then until a restart.
	logic               full_q;

	logic [CMP_W-1:0]   scaled;
	logic               allow;
	logic [TOTAL_W:0]   sum;
	logic               sum_full;

	assign scaled   = CMP_W'({req.prod, {CMP_SHIFT{1'b0}}});
	assign allow    = !full_q && (scaled >= thresh_q);
	assign sum      = {1'b0, sent_q} + (TOTAL_W+1)'(req.add);
	assign sum_full = sum[TOTAL_W] || (&sum[TOTAL_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q   <= '0;
			thresh_q <= CMP_W'(MS_SCALE);
			full_q   <= 1'b0;
			status_q <= STATUS_BLOCK;
		end else if (load) begin
			unique case (req.kind)
				KIND_RESTART: begin
					sent_q   <= '0;
					thresh_q <= CMP_W'(MS_SCALE);
					full_q   <= 1'b0;
					status_q <= STATUS_BLOCK;
				end
				KIND_PROBE: begin
					if (allow) begin
						sent_q   <= sum_full ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
						thresh_q <= thresh_q + CMP_W'(req.add_x125);
						full_q   <= sum_full;
						status_q <= STATUS_SENT;
					end else begin
						status_q <= STATUS_BLOCK;
					end
				end
				default: begin
					status_q <= STATUS_BLOCK;
				end
			endcase
		end
	end

endmodule

>>> src/average_rate_send_pacer_core.sv
// Top level of the average-rate send pacer: handshakes, APB register, window pipeline.
// Depends on arsp_pkg and arsp_ledger.
//
// Path: an input transfer is registered in stage 1, then in the ledger request, then in the output register.
// Throughput: one item per cycle unless out_stall holds the output; the three registered stages advance independently.
// The 32x20 elapsed-times-rate multiply owns the middle stage.
// Reset: rate 0, window marked hungry, byte count 0, pipeline empty.
`timescale 1ns / 1ps

module average_rate_send_pacer_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [arsp_pkg::APB_AW-1:0]       paddr,
	input  logic [arsp_pkg::APB_DW-1:0]       pwdata,
	output logic [arsp_pkg::APB_DW-1:0]       prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              mode,
	input  logic [arsp_pkg::NOW_W-1:0]        now_ms,
	input  logic [arsp_pkg::BYTES_W-1:0]      new_bytes,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              status
);
	import arsp_pkg::*;

	logic [RATE_W-1:0]  rate_q;
	logic               hungry_q;
	logic               rewritten_q;
	logic [NOW_W-1:0]   window_start_q;

	logic               v_s1;
	logic               v_s2;
	logic               out_valid_q;

	item_kind_t         kind_s1;
	logic [NOW_W-1:0]   elapsed_s1;
	logic [ADDX_W-1:0]  addx_s1;
	logic [BYTES_W-1:0] add_s1;

	ledger_req_t        req_s2;

	logic               cfg_wr;
	logic               reg_hit;
	logic               ready_out;
	logic               ready_s2;
	logic               ready_s1;
	logic               accept;
	logic               adv1;
	logic               adv2;
	item_kind_t         kind_in;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[APB_AW-1:2] == REG_TARGET_RATE);
	assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
	assign prdata  = reg_hit ? APB_DW'(rate_q) : '0;

	assign ready_out = !out_valid_q || !out_stall;
	assign adv2      = v_s2 && ready_out;
	assign ready_s2  = !v_s2 || ready_out;
	assign adv1      = v_s1 && ready_s2;
	assign ready_s1  = !v_s1 || ready_s2;
	assign in_stall  = !ready_s1;
	assign accept    = in_valid && ready_s1;
	assign out_valid = out_valid_q;

	// The restart decision is made at the transfer, so later items already see the new window.
	always_comb begin
		priority if (mode == MODE_HUNGRY) begin
			kind_in = KIND_HUNGRY;
		end else if (hungry_q || rewritten_q) begin
			kind_in = KIND_RESTART;
		end else begin
			kind_in = KIND_PROBE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q         <= '0;
			hungry_q       <= 1'b1;
			rewritten_q    <= 1'b0;
			window_start_q <= '0;
		end else begin
			if (accept) begin
				if (mode == MODE_HUNGRY) begin
					hungry_q <= 1'b1;
				end else begin
					hungry_q    <= 1'b0;
					rewritten_q <= 1'b0;
					if (kind_in == KIND_RESTART) begin
						window_start_q <= now_ms;
					end
				end
			end
			if (cfg_wr) begin
				rate_q      <= pwdata[RATE_W-1:0];
				rewritten_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (adv1) begin
				v_s1 <= 1'b0;
			end
			if (adv1) begin
				v_s2 <= 1'b1;
			end else if (adv2) begin
				v_s2 <= 1'b0;
			end
			if (adv2) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1    <= kind_in;
			elapsed_s1 <= now_ms - window_start_q;
			addx_s1    <= ADDX_W'(new_bytes) * ADDX_W'(MS_SCALE);
			add_s1     <= new_bytes;
		end
		if (adv1) begin
			req_s2.kind     <= kind_s1;
			req_s2.prod     <= PROD_W'(elapsed_s1) * PROD_W'(rate_q);
			req_s2.add_x125 <= addx_s1;
			req_s2.add      <= add_s1;
		end
	end

	arsp_ledger u_ledger (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv2),
		.req      (req_s2),
		.status_q (status)
	);

endmodule

>>> verif/average_rate_send_pacer_core_tb.sv
// Self-checking testbench for average_rate_send_pacer_core: paced probe and hungry transfers
// are checked against a cycle-free model of the send window. Needs arsp_pkg and the core RTL.
`timescale 1ns / 1ps

module average_rate_send_pacer_core_tb;

	import arsp_pkg::*;

	localparam int unsigned CYCLE_LIMIT      = 400000;
	localparam int unsigned SETTLE_CYCLES    = 8;
	localparam int unsigned RANDOM_ITEMS     = 1930;
	localparam longint unsigned BYTES_MAX    = 64'hFFFF_FFFF_FFFF;
	localparam longint unsigned BYTES_PER_KBIT_S = 128;
	localparam longint unsigned MS_PER_S     = 1000;
	localparam logic [RATE_W-1:0] RATE_MAX   = '1;
	localparam logic [APB_AW-1:0] RATE_ADDR  = {REG_TARGET_RATE, 2'b00};

	typedef struct {
		logic               mode;
		logic [NOW_W-1:0]   now;
		logic [BYTES_W-1:0] nbytes;
	} probe_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [APB_AW-1:0]   paddr = '0;
	logic [APB_DW-1:0]   pwdata = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                mode = MODE_PROBE;
	logic [NOW_W-1:0]    now_ms = '0;
	logic [BYTES_W-1:0]  new_bytes = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                status;

	// Window model.
	logic [RATE_W-1:0]   rate_kbit = '0;
	logic                win_hungry = 1'b1;
	logic                rate_dirty = 1'b0;
	logic [NOW_W-1:0]    win_start = '0;
	longint unsigned     bytes_sent = 0;

	probe_t              send_q[$];
	logic                status_q[$];
	probe_t              cur_item;
	logic                in_taken = 1'b0;
	logic                exp_status;
	int unsigned         burst_left = 1;
	int unsigned         gap_left = 0;
	int unsigned         rx_cycle = 0;
	int unsigned         rx_mode = 0;
	int unsigned         cycle_cnt = 0;
	int unsigned         err_cnt = 0;
	int unsigned         n_items = 0;
	int unsigned         n_checked = 0;
	int unsigned         n_sent = 0;
	int unsigned         n_blocked = 0;
	int unsigned         n_restart = 0;
	int unsigned         n_hungry = 0;
	int unsigned         n_rates = 0;

	average_rate_send_pacer_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.now_ms    (now_ms),
		.new_bytes (new_bytes),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Returns the status of one item and advances the window state.
	function automatic logic pace_predict(logic m, logic [NOW_W-1:0] now,
			logic [BYTES_W-1:0] add);
		logic [NOW_W-1:0] elapsed;
		longint unsigned  allowance;
		longint unsigned  charged;
		if (m == MODE_HUNGRY) begin
			win_hungry = 1'b1;
			n_hungry++;
			return STATUS_BLOCK;
		end
		if (win_hungry || rate_dirty) begin
			win_hungry = 1'b0;
			rate_dirty = 1'b0;
			win_start = now;
			bytes_sent = 0;
			n_restart++;
			return STATUS_BLOCK;
		end
		elapsed = now - win_start;
		allowance = (64'(elapsed) * 64'(rate_kbit) * BYTES_PER_KBIT_S) / MS_PER_S;
		if (allowance > BYTES_MAX)
			allowance = BYTES_MAX;
		if (allowance > bytes_sent) begin
			charged = bytes_sent + 64'(add);
			bytes_sent = (charged > BYTES_MAX) ? BYTES_MAX : charged;
			n_sent++;
			return STATUS_SENT;
		end
		n_blocked++;
		return STATUS_BLOCK;
	endfunction

	task automatic queue_item(logic m, logic [NOW_W-1:0] now, logic [BYTES_W-1:0] nb);
		probe_t p;
		p.mode = m;
		p.now = now;
		p.nbytes = nb;
		send_q.push_back(p);
		n_items++;
	endtask

	// Waits until the block has nothing in flight.
	task automatic settle();
		while (send_q.size() != 0 || in_valid || status_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the rate register, then reads it back.
	task automatic rate_write(logic [RATE_W-1:0] rate);
		logic [APB_DW-1:0] rd;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= RATE_ADDR;
		pwdata <= APB_DW'(rate);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rate_kbit = rate;
		rate_dirty = 1'b1;
		n_rates++;
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd !== APB_DW'(rate)) begin
			err_cnt++;
			$display("%0t: rate readback expected %h actual %h", $time, APB_DW'(rate), rd);
		end
	endtask

	// Mostly coherent windows: a running tick with small steps, some backward jumps,
	// hungry marks that force a restart, and a little noise with arbitrary fields.
	task automatic gen_phase(int unsigned n, logic [RATE_W-1:0] rate);
		logic [NOW_W-1:0] tick;
		int unsigned      per_ms;
		int unsigned      lim;
		int unsigned      roll;
		per_ms = (int'(rate) * 128) / 1000;
		lim = per_ms * 6 + 4;
		if (lim > 24'hFF_FFFF)
			lim = 24'hFF_FFFF;
		tick = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 200) : $urandom;
		for (int unsigned k = 0; k < n; k++) begin
			roll = $urandom_range(0, 99);
			if (roll < 3) begin
				queue_item(1'($urandom_range(0, 1)), $urandom, BYTES_W'($urandom));
			end else if (roll < 9) begin
				queue_item(MODE_HUNGRY, $urandom, BYTES_W'($urandom));
			end else begin
				if (roll < 12)
					tick = tick - $urandom_range(1, 1000);
				else if ($urandom_range(0, 3) != 0)
					tick = tick + $urandom_range(1, 12);
				queue_item(MODE_PROBE, tick, BYTES_W'($urandom_range(0, lim)));
			end
		end
	endtask

	// Sender: bursts of random length separated by random gaps.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (send_q.size() != 0) begin
				cur_item = send_q.pop_front();
				mode <= cur_item.mode;
				now_ms <= cur_item.now;
				new_bytes <= cur_item.nbytes;
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: a new stall pattern is drawn periodically; two long hold-offs let the
	// pipeline fill so that the input side has to stall.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			rx_cycle <= rx_cycle + 1;
			if (rx_cycle % 50 == 0)
				rx_mode <= $urandom_range(0, 3);
			if ((rx_cycle >= 1500 && rx_cycle < 1900) || (rx_cycle >= 9000 && rx_cycle < 9300)) begin
				out_stall <= 1'b1;
			end else begin
				case (rx_mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= rx_cycle[0];
				endcase
			end
		end
	end

	// Checks each result transfer and predicts each input transfer.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (status_q.size() == 0) begin
					err_cnt++;
					$display("%0t: result transfer with status %0b, expected none", $time, status);
				end else begin
					exp_status = status_q.pop_front();
					n_checked++;
					if (status !== exp_status) begin
						err_cnt++;
						$display("%0t: status expected %0b actual %0b", $time, exp_status, status);
					end
				end
			end
			in_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall)
				status_q.push_back(pace_predict(mode, now_ms, new_bytes));
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt, status_q.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int unsigned      done;
		int unsigned      n;
		int unsigned      phase;
		logic [RATE_W-1:0] rate;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Out of reset the window is hungry and the rate is zero.
		queue_item(MODE_PROBE, 32'd5, 24'd10);
		queue_item(MODE_PROBE, 32'd100, 24'd1);
		settle();

		rate_write(RATE_MAX);
		queue_item(MODE_PROBE, 32'd0, 24'hFF_FFFF);
		queue_item(MODE_PROBE, 32'd0, 24'hFF_FFFF);
		queue_item(MODE_PROBE, 32'd1, 24'hFF_FFFF);
		queue_item(MODE_PROBE, 32'd2, 24'd0);
		// Elapsed time near 2^32 makes the allowance saturate.
		queue_item(MODE_PROBE, 32'hFFFF_FFFF, 24'hFF_FFFF);
		queue_item(MODE_HUNGRY, 32'hFFFF_FFFF, 24'hFF_FFFF);
		queue_item(MODE_PROBE, 32'h8000_0000, 24'd0);
		// A tick that went backwards reads as a long elapsed time.
		queue_item(MODE_PROBE, 32'h7FFF_FFFF, 24'h00_0001);
		queue_item(MODE_HUNGRY, 32'd0, 24'd0);
		queue_item(MODE_HUNGRY, 32'd1, 24'd1);
		queue_item(MODE_PROBE, 32'hFFFF_FFF0, 24'h80_0000);
		queue_item(MODE_PROBE, 32'h0000_0010, 24'd1);
		settle();

		// Slowest rate: one byte is allowed every 7.8 ms.
		rate_write(RATE_W'(1));
		queue_item(MODE_PROBE, 32'd0, 24'd1);
		queue_item(MODE_PROBE, 32'd7, 24'd1);
		queue_item(MODE_PROBE, 32'd8, 24'd1);
		queue_item(MODE_PROBE, 32'd15, 24'd1);
		queue_item(MODE_PROBE, 32'd16, 24'd1);
		settle();

		done = 0;
		phase = 0;
		while (done < RANDOM_ITEMS) begin
			case (phase)
				0: rate = '0;
				1: rate = RATE_W'(1);
				2: rate = RATE_MAX;
				3: rate = RATE_W'(8);
				default: rate = ($urandom_range(0, 1) == 0) ? RATE_W'($urandom_range(1, 20000))
					: RATE_W'($urandom);
			endcase
			n = $urandom_range(120, 220);
			rate_write(rate);
			gen_phase(n, rate);
			settle();
			done += n;
			phase++;
		end

		if (status_q.size() != 0) begin
			err_cnt++;
			$display("%0t: %0d expected results never arrived", $time, status_q.size());
		end
		$display("Ran %0d items over %0d rate settings, %0d results checked", n_items, n_rates,
			n_checked);
		$display("Probes sent %0d, blocked %0d, window restarts %0d, hungry marks %0d",
			n_sent, n_blocked, n_restart, n_hungry);
		if (err_cnt == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

>>> filelist.f
src/arsp_pkg.sv
src/arsp_ledger.sv
src/average_rate_send_pacer_core.sv
verif/average_rate_send_pacer_core_tb.sv
